// ----- hdl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants for the block bitmap allocator
// Request kinds, store geometry and the front-to-back command record.
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;
	localparam int unsigned BitmapBytes = 4096;
	localparam int unsigned AddrW       = $clog2(BitmapBytes);
	localparam int unsigned NumBits     = BitmapBytes * 8;
	localparam int unsigned BitW        = 15;
	localparam int unsigned CountW      = 16;
	localparam logic [7:0]  FullByte    = 8'd255;
	localparam int unsigned QDepth      = 2;

	typedef enum logic [2:0] {
		K_TEST      = 3'd0,
		K_SET       = 3'd1,
		K_CLEAR     = 3'd2,
		K_CLR_RANGE = 3'd3,
		K_ALLOC_BYT = 3'd4,
		K_ALLOC_BIT = 3'd5,
		K_WR_BYTE   = 3'd6,
		K_RD_BYTE   = 3'd7
	} kind_t;

	// Front end resolves the walk range in bits; back end walks bytes.
	typedef struct packed {
		kind_t        kind;
		logic [16:0]  start;  // first bit (alloc byte: rounded up)
		logic [16:0]  stop;   // exclusive end bit
		logic [7:0]   data;
		logic [BitW-1:0] idx;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- hdl/bba_front.sv -----
// ----------------------------------------------------------------------------
// bba_front: request intake and classification
// Computes walk bounds per request and pushes commands into a small queue.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      valid,
	output logic                           stall,
	input  wire logic [2:0]                kind,
	input  wire logic [bba_pkg::BitW-1:0]  bit_pos,
	input  wire logic [15:0]               count,
	input  wire logic [15:0]               limit,
	input  wire logic [7:0]                data,
	output logic                           cmd_valid,
	input  wire logic                      cmd_take,
	output bba_pkg::cmd_t                  cmd
);
	bba_pkg::cmd_t q_mem_q [bba_pkg::QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	bba_pkg::cmd_t nc;
	logic [16:0] bound, endr, nbits;
	logic push;

	always_comb begin
		nbits = 17'(bba_pkg::NumBits);
		bound = ({1'b0, limit} < nbits) ? {1'b0, limit} : nbits;
		endr  = 17'(bit_pos) + 17'(count);
		if (endr > nbits) endr = nbits;
		nc.kind  = bba_pkg::kind_t'(kind);
		nc.data  = data;
		nc.idx   = bit_pos;
		nc.start = 17'(bit_pos);
		nc.stop  = bound;
		case (bba_pkg::kind_t'(kind))
			bba_pkg::K_CLR_RANGE: nc.stop = endr;
			bba_pkg::K_ALLOC_BYT: nc.start = (17'(bit_pos) + 17'd7) & ~17'd7;
			default: ;
		endcase
	end

	assign stall     = (cnt_q == 2'(bba_pkg::QDepth));
	assign push      = valid && !stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= nc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_take);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/bba_back.sv -----
// ----------------------------------------------------------------------------
// bba_back: bitmap store and request execution
// Byte-wide store with a clearing pass, read-modify-write and byte walks.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_valid,
	output logic                           cmd_take,
	input  bba_pkg::cmd_t                  cmd,
	output logic                           valid,
	input  wire logic                      stall,
	output logic                           status,
	output logic [bba_pkg::BitW-1:0]       found_index,
	output logic                           is_free,
	output logic [7:0]                     read_data
);
	localparam int unsigned AW = bba_pkg::AddrW;

	logic [7:0] mem [bba_pkg::BitmapBytes];
	bba_pkg::state_t st_q, st_d;
	logic [AW:0]   clr_q;
	logic          clearing;
	logic [16:0]   pos_q, pos_d;
	logic [7:0]    rd_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;
	logic          out_v_q;
	logic          r_st_q, r_fr_q;
	logic [bba_pkg::BitW-1:0] r_fi_q;
	logic [7:0]    r_rd_q;
	logic          fin, f_st, f_fr;
	logic [bba_pkg::BitW-1:0] f_fi;
	logic [7:0]    f_rd;
	logic [2:0]    bo;
	logic [7:0]    lo_mask, hi_mask, wmask, clrv, avail;
	logic [16:0]   byte_base, byte_end;
	logic          inrange;
	logic [2:0]    pick;
	logic          hit;

	assign clearing = !clr_q[AW];
	assign raddr    = pos_q[AW+2:3];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bba_pkg::ST_IDLE; clr_q <= '0; out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			if (fin) out_v_q <= 1'b1;
			else if (!stall) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (fin) begin
			r_st_q <= f_st; r_fi_q <= f_fi; r_fr_q <= f_fr; r_rd_q <= f_rd;
		end
	end

	// masks for the bits of the current byte inside [start, stop)
	always_comb begin
		byte_base = {pos_q[16:3], 3'b000};
		byte_end  = byte_base + 17'd8;
		bo        = pos_q[2:0];
		lo_mask   = 8'hFF << bo;
		hi_mask   = (cmd.stop >= byte_end) ? 8'hFF :
			(8'hFF >> (4'd8 - 4'(cmd.stop - byte_base)));
		wmask     = lo_mask & hi_mask;
		inrange   = pos_q < cmd.stop;
		avail     = ~rd_q & wmask;
		hit       = 1'b0; pick = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (avail[i]) begin hit = 1'b1; pick = 3'(i); end
		end
		clrv = rd_q & ~wmask;
	end

	always_comb begin
		st_d = st_q; pos_d = pos_q; cmd_take = 1'b0;
		we = 1'b0; waddr = pos_q[AW+2:3]; wdata = rd_q;
		fin = 1'b0; f_st = 1'b0; f_fi = '0; f_fr = 1'b0; f_rd = '0;
		if (clearing) begin
			we = 1'b1; waddr = clr_q[AW-1:0]; wdata = 8'd0;
		end
		unique case (st_q)
			bba_pkg::ST_IDLE: begin
				pos_d = cmd.start;
				if (!clearing && cmd_valid && !out_v_q) begin
					if (cmd.kind == bba_pkg::K_WR_BYTE) begin
						if (17'(cmd.idx) < 17'(bba_pkg::BitmapBytes)) begin
							we = 1'b1; waddr = AW'(cmd.idx); wdata = cmd.data;
						end
						fin = 1'b1; cmd_take = 1'b1;
					end else if (cmd.kind == bba_pkg::K_RD_BYTE) begin
						pos_d = 17'({cmd.idx[AW-1:0], 3'b000});
						if (17'(cmd.idx) < 17'(bba_pkg::BitmapBytes)) st_d = bba_pkg::ST_READ;
						else begin fin = 1'b1; cmd_take = 1'b1; end
					end else st_d = bba_pkg::ST_READ;
				end
			end
			bba_pkg::ST_READ: st_d = bba_pkg::ST_EVAL;
			bba_pkg::ST_EVAL: begin
				st_d = bba_pkg::ST_DONE;
				case (cmd.kind)
					bba_pkg::K_TEST: f_fr = !rd_q[bo];
					bba_pkg::K_SET: begin we = 1'b1; wdata = rd_q | (8'd1 << bo); end
					bba_pkg::K_CLEAR: begin we = 1'b1; wdata = rd_q & ~(8'd1 << bo); end
					bba_pkg::K_RD_BYTE: f_rd = rd_q;
					bba_pkg::K_CLR_RANGE: begin
						if (inrange) begin
							we = 1'b1; wdata = clrv;
							if (byte_end < cmd.stop) begin
								pos_d = byte_end; st_d = bba_pkg::ST_READ;
							end
						end
					end
					bba_pkg::K_ALLOC_BYT: begin
						f_st = 1'b1;
						if (inrange) begin
							if (rd_q == 8'd0) begin
								we = 1'b1; wdata = 8'd1; f_st = 1'b0; f_fi = pos_q[14:0];
							end else begin
								pos_d = byte_end; st_d = bba_pkg::ST_READ;
							end
						end
					end
					default: begin // alloc free bit
						f_st = 1'b1;
						if (inrange) begin
							if (hit) begin
								we = 1'b1; wdata = rd_q | (8'd1 << pick);
								f_st = 1'b0; f_fi = {byte_base[14:3], pick};
							end else if (byte_end < cmd.stop) begin
								pos_d = byte_end; st_d = bba_pkg::ST_READ;
							end
						end
					end
				endcase
				if (st_d == bba_pkg::ST_DONE) begin
					fin = 1'b1; cmd_take = 1'b1; st_d = bba_pkg::ST_IDLE;
				end
			end
			default: st_d = bba_pkg::ST_IDLE;
		endcase
	end

	assign valid       = out_v_q;
	assign status      = r_st_q;
	assign found_index = r_fi_q;
	assign is_free     = r_fr_q;
	assign read_data   = r_rd_q;
endmodule
`default_nettype wire

// ----- hdl/block_bitmap_allocator.sv -----
// ----------------------------------------------------------------------------
// block_bitmap_allocator: bitmap free-space allocator, top level
// Input channel: valid/stall with kind, bit_pos, count, limit, data.
// Output channel: valid/stall with status, found_index, is_free, read_data.
// Every request gives exactly one result transfer.
// A two-entry queue decouples intake from the execution unit, so requests
// are taken while a result is still waiting on the output register.
// Byte writes finish from idle; test/set/clear/read pass through the read
// and evaluate states. Clear range and searches repeat read and evaluate
// for each byte walked, set by the registered store read in the walk loop.
// A request starts only once the previous result has left, so requests do
// not overlap in the execution unit.
// After reset the store is cleared one byte per cycle, during which no
// request is executed (intake queue still fills).
// When the receiver stalls the result holds and the back end waits; the
// queue absorbs up to two more requests before input stall rises.
// ----------------------------------------------------------------------------
`default_nettype none
module block_bitmap_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [2:0]                kind,
	input  wire logic [14:0]               bit_pos,
	input  wire logic [15:0]               count,
	input  wire logic [15:0]               limit,
	input  wire logic [7:0]                data,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           status,
	output logic [14:0]                    found_index,
	output logic                           is_free,
	output logic [7:0]                     read_data
);
	logic          cmd_valid, cmd_take;
	bba_pkg::cmd_t cmd;

	bba_front u_front (
		.clk, .arst_n, .valid(in_valid), .stall(in_stall),
		.kind, .bit_pos, .count, .limit, .data,
		.cmd_valid, .cmd_take, .cmd
	);

	bba_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd,
		.valid(out_valid), .stall(out_stall),
		.status, .found_index, .is_free, .read_data
	);
endmodule
`default_nettype wire

// ----- hdl/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker: port-level checks for the block bitmap allocator
// Watches handshakes and result field consistency.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        status,
	input wire logic [14:0] found_index,
	input wire logic        is_free
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("request dropped while stalled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found_index))
		else $error("result dropped while stalled");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> found_index == 15'd0 && !is_free)
		else $error("failed allocation carries data");
	a_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_free |-> !status && found_index == 15'd0)
		else $error("test result mixes fields");
	a_no_out_rst: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("result after reset");
endmodule

bind block_bitmap_allocator bba_checker u_bba_checker (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.status, .found_index, .is_free
);
`default_nettype wire
